### rtl/modular_exponent_and_inverse_unit_assert.svh
// Assertion macros for the modular exponent and inverse unit.
`ifndef MODULAR_EXPONENT_AND_INVERSE_UNIT_ASSERT_SVH
`define MODULAR_EXPONENT_AND_INVERSE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MEXI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("mexi assertion failed");
`define MEXI_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) \
		else $error("mexi forbidden condition seen");
`else
`define MEXI_ASSERT(lbl, clk, rst_n, prop)
`define MEXI_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

### rtl/mexi_pkg.sv
// Package with the shared types and constants of the modular exponent and inverse unit.
package mexi_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int MOD_RESET = 3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV3,
		S_MUL,
		S_NEXT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_RED,
		OP_ACC,
		OP_SQR
	} op_t;

endpackage

### rtl/modular_exponent_and_inverse_unit.sv
// Top level of the modular exponent and inverse unit: sequencer and datapath registers.
//
// channel   direction  handshake            payload
// cfg       in         cfg_wr_en            cfg_wr_data (modulus)
// request   in         in_valid / in_stall  req_type, base, exponent
// answer    out        out_valid / out_stall result
//
// One word is in flight at a time; in_stall is high from acceptance until the answer is taken.
// Per word the unit first works out the inverse exponent for an inverse request, then reduces
// the base, then does a squaring for each exponent bit below the highest set one and a multiply
// for each set bit, each step followed by a decision state.
// The single modular adder does each multiply: one doubling per cycle, paused by an add on a set bit.
// Reset clears the sequencer and loads the modulus with 3; a stalled answer holds its value.
`include "modular_exponent_and_inverse_unit_assert.svh"
module modular_exponent_and_inverse_unit import mexi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [WORD_BITS-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [WORD_BITS-1:0] base,
	input  logic [WORD_BITS-1:0] exponent,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] result
);

	localparam int CNT_W = ($clog2(WORD_BITS) > 4) ? $clog2(WORD_BITS) : 4;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
	localparam logic [CNT_W-1:0] FOLD_HALF_STEPS = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_SUB_STEP = CNT_W'(8);
	localparam logic [CNT_W-1:0] DIV_MUL_FIRST = CNT_W'(9);
	localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(13);
	localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);
	localparam logic [WORD_BITS-1:0] ZERO_W = '0;
	localparam logic [WORD_BITS-1:0] ONES_W = '1;

	state_t               state_q;
	state_t               state_nxt;
	op_t                  op_q;
	logic [WORD_BITS-1:0] mod_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] t_q;
	logic [WORD_BITS-1:0] xop_q;
	logic [WORD_BITS-1:0] ysh_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 phase_q;

	logic                 in_acc;
	logic                 out_acc;
	logic                 ysh_msb;
	logic [WORD_BITS-1:0] am_y;
	logic [WORD_BITS-1:0] am_s;
	logic                 mul_shift;
	logic                 mul_last;
	logic                 div_last;
	logic [6:0]           fold_sh;
	logic [CNT_W-1:0]     mul_idx;
	logic [6:0]           mul_sh;
	logic [WORD_BITS-1:0] fold_lo;
	logic [WORD_BITS-1:0] fold_sum;
	logic [1:0]           div_rem;
	logic [WORD_BITS-1:0] div_y;
	logic [WORD_BITS-1:0] mul_sum;
	logic [WORD_BITS-1:0] inv_exp;

	mexi_addmod #(
		.WORD_BITS(WORD_BITS)
	) u_addmod (
		.x(t_q),
		.y(am_y),
		.m(mod_q),
		.s(am_s)
	);

	// The inverse exponent is found without a divider: the modulus is folded on even bit
	// boundaries down to its remainder by 3, the remainder is subtracted, and the negated exact
	// quotient comes from multiplying by minus the inverse of 3 modulo the word size.
	always_comb begin
		in_acc    = in_valid && !in_stall;
		out_acc   = out_valid && !out_stall;
		ysh_msb   = ysh_q[WORD_BITS-1];
		am_y      = phase_q ? xop_q : t_q;
		mul_shift = (state_q == S_MUL) && (phase_q || !ysh_msb);
		mul_last  = mul_shift && (cnt_q == CNT_LAST);
		div_last  = (state_q == S_DIV3) && (cnt_q == DIV_LAST_STEP);
		fold_sh   = (cnt_q < FOLD_HALF_STEPS) ? (7'd32 >> cnt_q) : 7'd2;
		mul_idx   = cnt_q - DIV_MUL_FIRST;
		mul_sh    = 7'd2 << mul_idx;
		fold_lo   = ysh_q & ~(ONES_W << fold_sh);
		fold_sum  = (ysh_q >> fold_sh) + fold_lo;
		div_rem   = (ysh_q[1:0] == 2'd3) ? 2'd0 : ysh_q[1:0];
		div_y     = mod_q - {{(WORD_BITS-2){1'b0}}, div_rem};
		mul_sum   = exp_q + (exp_q << mul_sh);
		inv_exp   = {~mul_sum[WORD_BITS-2:0], 1'b1};
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (mod_q == ZERO_W) begin
						state_nxt = S_DONE;
					end else if (req_type) begin
						state_nxt = S_DIV3;
					end else begin
						state_nxt = S_MUL;
					end
				end
			end
			S_DIV3: begin
				if (div_last) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				if (mul_last) begin
					state_nxt = S_NEXT;
				end
			end
			S_NEXT: begin
				state_nxt = (exp_q == ZERO_W) ? S_DONE : S_MUL;
			end
			S_DONE: begin
				if (out_acc) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		out_valid = (state_q == S_DONE);
		result    = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RED;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			mod_q   <= WORD_BITS'(MOD_RESET);
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				mod_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					op_q    <= OP_RED;
					phase_q <= 1'b0;
					cnt_q   <= '0;
				end
				S_DIV3: begin
					cnt_q <= div_last ? '0 : cnt_q + 1'b1;
				end
				S_MUL: begin
					if (!phase_q && ysh_msb) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						cnt_q   <= mul_last ? '0 : cnt_q + 1'b1;
					end
				end
				S_NEXT: begin
					cnt_q   <= '0;
					phase_q <= 1'b0;
					op_q    <= exp_q[0] ? OP_ACC : OP_SQR;
				end
				S_DONE: begin
					cnt_q <= '0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					base_q <= base;
					exp_q  <= exponent;
					res_q  <= (mod_q == ZERO_W || mod_q == ONE_W) ? ZERO_W : ONE_W;
					t_q    <= ZERO_W;
					xop_q  <= ONE_W;
					ysh_q  <= req_type ? mod_q : base;
				end
			end
			S_DIV3: begin
				if (div_last) begin
					exp_q <= inv_exp;
					ysh_q <= base_q;
					t_q   <= ZERO_W;
				end else if (cnt_q > DIV_SUB_STEP) begin
					exp_q <= mul_sum;
				end else if (cnt_q == DIV_SUB_STEP) begin
					exp_q <= div_y;
				end else begin
					ysh_q <= fold_sum;
				end
			end
			S_MUL: begin
				t_q <= am_s;
				if (mul_shift) begin
					ysh_q <= ysh_q << 1;
				end
				if (mul_last) begin
					unique case (op_q)
						OP_RED: begin
							base_q <= am_s;
						end
						OP_ACC: begin
							res_q    <= am_s;
							exp_q[0] <= 1'b0;
						end
						OP_SQR: begin
							base_q <= am_s;
							exp_q  <= exp_q >> 1;
						end
						default: begin
							base_q <= am_s;
						end
					endcase
				end
			end
			S_NEXT: begin
				t_q   <= ZERO_W;
				ysh_q <= base_q;
				xop_q <= exp_q[0] ? res_q : base_q;
			end
			S_DONE: begin
				t_q <= t_q;
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	`MEXI_ASSERT_NEVER(a_idle_not_done, clk, arst_n, out_valid && !in_stall)
	`MEXI_ASSERT(a_zero_mod_done, clk, arst_n, (in_acc && mod_q == ZERO_W) |=> out_valid)
	`MEXI_ASSERT(a_add_phase_bit, clk, arst_n, (state_q == S_MUL && phase_q) |-> ysh_msb)
	`MEXI_ASSERT(a_exp_done, clk, arst_n, (state_q == S_NEXT && exp_q == ZERO_W) |=> out_valid)

endmodule

### rtl/mexi_addmod.sv
// Modular adder shared by all shift-add steps of the unit.
module mexi_addmod import mexi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic [WORD_BITS-1:0] s
);

	logic [WORD_BITS:0] sum;
	logic [WORD_BITS:0] diff;
	logic               ge;

	always_comb begin
		sum  = {1'b0, x} + {1'b0, y};
		diff = sum - {1'b0, m};
		ge   = (sum >= {1'b0, m});
		s    = ge ? diff[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
	end

endmodule
